// File: hw/rtl/tls_pkg.sv
// Shared types and constants for the text line segmenter.
`default_nettype none

package tls_pkg;

  // Rows per image that are tracked; later rows are ignored.
  localparam int unsigned MaxRows    = 4096;
  localparam int unsigned RowW       = $clog2(MaxRows) + 1;  // counter can hold MaxRows
  localparam int unsigned TopW       = $clog2(MaxRows);
  localparam int unsigned SegCap     = 128;
  localparam int unsigned LineNumW   = 7;

  localparam int unsigned PixW       = 8;
  localparam int unsigned GapW       = 12;
  localparam int unsigned MinHW      = 12;
  localparam int unsigned MaxSegW    = 8;
  localparam int unsigned ApbAddrW   = 4;
  localparam int unsigned ApbDataW   = 32;

  localparam logic [PixW-1:0]    DarkThresholdRst = 8'd200;
  localparam logic [GapW-1:0]    GapToleranceRst  = 12'd1;
  localparam logic [MinHW-1:0]   MinHeightRst     = 12'd5;
  localparam logic [MaxSegW-1:0] MaxSegmentsRst   = 8'd100;

  // Register indexes (paddr[3:2]).
  typedef enum logic [1:0] {
    RegDarkThreshold = 2'd0,
    RegGapTolerance  = 2'd1,
    RegMinHeight     = 2'd2,
    RegMaxSegments   = 2'd3
  } tls_reg_e;

  typedef struct packed {
    logic [PixW-1:0]    dark_threshold;
    logic [GapW-1:0]    gap_tolerance;
    logic [MinHW-1:0]   min_height;
    logic [MaxSegW-1:0] max_segments;
  } tls_cfg_t;

  typedef struct packed {
    logic [LineNumW-1:0] line_number;
    logic [RowW-1:0]     line_bottom;
    logic [TopW-1:0]     line_top;
  } tls_line_t;

endpackage

`default_nettype wire

// File: hw/rtl/tls_tracker.sv
// Per-pixel darkness test and row/line state tracking.
`default_nettype none

module tls_tracker import tls_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tls_cfg_t        cfg_i,
  input  wire logic            fire_i,
  input  wire logic [PixW-1:0] red_i,
  input  wire logic [PixW-1:0] green_i,
  input  wire logic [PixW-1:0] blue_i,
  input  wire logic            row_end_i,
  input  wire logic            image_end_i,
  output logic                 res_valid_o,
  output tls_line_t            res_line_o,
  output logic                 res_flush_o
);

  localparam logic [RowW-1:0]    BlankMax  = {RowW{1'b1}};
  localparam logic [MaxSegW-1:0] SegCapVal = MaxSegW'(SegCap);

  logic                row_inked_q, row_inked_d;
  logic [RowW-1:0]     row_counter_q, row_counter_d;
  logic                in_line_q, in_line_d;
  logic [TopW-1:0]     open_top_q, open_top_d;
  logic [RowW-1:0]     blank_run_q, blank_run_d;
  logic [MaxSegW-1:0]  lines_found_q, lines_found_d;

  logic                dark, inked, row_done, row_ok, close, room;
  logic [RowW-1:0]     blank_inc, y1, line_end, height;
  logic [MaxSegW-1:0]  seg_limit;
  logic                emit_close, emit_flush;
  logic [TopW-1:0]     cur_top;
  logic [RowW-1:0]     cur_rows;

  always_comb begin
    dark      = (red_i < cfg_i.dark_threshold) && (green_i < cfg_i.dark_threshold) &&
                (blue_i < cfg_i.dark_threshold);
    inked     = row_inked_q | dark;
    row_done  = row_end_i | image_end_i;
    row_ok    = row_counter_q < RowW'(MaxRows);
    seg_limit = (cfg_i.max_segments > SegCapVal) ? SegCapVal : cfg_i.max_segments;
    room      = lines_found_q < seg_limit;
    blank_inc = (blank_run_q == BlankMax) ? blank_run_q : blank_run_q + RowW'(1);
    close     = blank_inc > {1'b0, cfg_i.gap_tolerance};
    y1        = row_counter_q + RowW'(1);
    line_end  = (y1 >= blank_inc) ? y1 - blank_inc : '0;
    height    = (line_end >= {1'b0, open_top_q}) ? line_end - {1'b0, open_top_q} : '0;

    row_inked_d   = inked;
    row_counter_d = row_counter_q;
    in_line_d     = in_line_q;
    open_top_d    = open_top_q;
    blank_run_d   = blank_run_q;
    lines_found_d = lines_found_q;
    emit_close    = 1'b0;
    emit_flush    = 1'b0;

    if (row_done) begin
      if (row_ok) begin
        if (inked) begin
          if (!in_line_q) begin
            open_top_d = row_counter_q[TopW-1:0];
            in_line_d  = 1'b1;
          end
          blank_run_d = '0;
        end else if (in_line_q) begin
          blank_run_d = blank_inc;
          if (close) begin
            emit_close  = (height > {1'b0, cfg_i.min_height}) && room;
            in_line_d   = 1'b0;
            blank_run_d = '0;
          end
        end
        row_counter_d = y1;
      end
      row_inked_d = 1'b0;
    end

    // Line start and image height as seen after this pixel's row, before the clear
    cur_top  = open_top_d;
    cur_rows = row_counter_d;

    // Flush a line still open at image end, then start the next image clean.
    if (image_end_i) begin
      emit_flush    = in_line_d && !emit_close && room;
      row_inked_d   = 1'b0;
      row_counter_d = '0;
      in_line_d     = 1'b0;
      open_top_d    = '0;
      blank_run_d   = '0;
      lines_found_d = '0;
    end else if (emit_close) begin
      lines_found_d = lines_found_q + MaxSegW'(1);
    end

    res_valid_o             = fire_i && (emit_close || emit_flush);
    res_flush_o             = emit_flush;
    res_line_o.line_number  = lines_found_q[LineNumW-1:0];
    res_line_o.line_top     = cur_top;
    res_line_o.line_bottom  = emit_flush ? cur_rows : line_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_inked_q   <= 1'b0;
      row_counter_q <= '0;
      in_line_q     <= 1'b0;
      open_top_q    <= '0;
      blank_run_q   <= '0;
      lines_found_q <= '0;
    end else if (fire_i) begin
      row_inked_q   <= row_inked_d;
      row_counter_q <= row_counter_d;
      in_line_q     <= in_line_d;
      open_top_q    <= open_top_d;
      blank_run_q   <= blank_run_d;
      lines_found_q <= lines_found_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/text_line_segmenter.sv
// Text line segmenter top level: stream ports, register file and result queue.
//
// Pixels stream in raster order, at most one transfer per clock; each transfer is
// classified and the row/line state updated in the same cycle, and any
// detected line (start row, exclusive end row, ordinal, flush flag) is
// written into a two-entry result queue. s_axis_tready stays high while
// the queue has a free entry, so the block takes one pixel every cycle
// whenever the result side keeps up. Registers: 0x0 dark threshold,
// 0x4 gap tolerance, 0x8 minimum height, 0xC segment limit; write them
// only while no image is in progress.
`default_nettype none

module text_line_segmenter import tls_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // APB register port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready,
  // pixel stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [23:0]         s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  wire logic                s_axis_tlast,  // row_end
  input  wire logic                s_axis_tuser,  // image_end
  // line stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [31:0]              m_axis_tdata,  // line_top[11:0], line_bottom[24:12],
                                                  // line_number[31:25]
  output logic                     m_axis_tuser   // at_image_end
);

  tls_cfg_t  cfg_q, cfg_d;
  logic      apb_wr;
  tls_reg_e  reg_sel;

  assign pready  = 1'b1;
  assign apb_wr  = psel && penable && pwrite;
  assign reg_sel = tls_reg_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (apb_wr) begin
      unique case (reg_sel)
        RegDarkThreshold: cfg_d.dark_threshold = pwdata[PixW-1:0];
        RegGapTolerance:  cfg_d.gap_tolerance  = pwdata[GapW-1:0];
        RegMinHeight:     cfg_d.min_height     = pwdata[MinHW-1:0];
        RegMaxSegments:   cfg_d.max_segments   = pwdata[MaxSegW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegDarkThreshold: prdata = ApbDataW'(cfg_q.dark_threshold);
      RegGapTolerance:  prdata = ApbDataW'(cfg_q.gap_tolerance);
      RegMinHeight:     prdata = ApbDataW'(cfg_q.min_height);
      RegMaxSegments:   prdata = ApbDataW'(cfg_q.max_segments);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_threshold <= DarkThresholdRst;
      cfg_q.gap_tolerance  <= GapToleranceRst;
      cfg_q.min_height     <= MinHeightRst;
      cfg_q.max_segments   <= MaxSegmentsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Line tracker
  logic      in_fire, res_valid, res_flush;
  tls_line_t res_line;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  tls_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fire_i      (in_fire),
    .red_i       (s_axis_tdata[7:0]),
    .green_i     (s_axis_tdata[15:8]),
    .blue_i      (s_axis_tdata[23:16]),
    .row_end_i   (s_axis_tlast),
    .image_end_i (s_axis_tuser),
    .res_valid_o (res_valid),
    .res_line_o  (res_line),
    .res_flush_o (res_flush)
  );

  // Two-entry result queue: head drives the port, tail holds a waiting line.
  logic [1:0] count_q, count_d;
  tls_line_t  head_line_q, head_line_d, tail_line_q, tail_line_d;
  logic       head_flush_q, head_flush_d, tail_flush_q, tail_flush_d;
  logic       out_fire;

  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (count_q != 2'd2);
  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tdata  = {head_line_q.line_number, head_line_q.line_bottom,
                          head_line_q.line_top};
  assign m_axis_tuser  = head_flush_q;

  always_comb begin
    count_d      = count_q;
    head_line_d  = head_line_q;
    head_flush_d = head_flush_q;
    tail_line_d  = tail_line_q;
    tail_flush_d = tail_flush_q;
    unique case ({res_valid, out_fire})
      2'b10: begin
        count_d = count_q + 2'd1;
        if (count_q == 2'd0) begin
          head_line_d  = res_line;
          head_flush_d = res_flush;
        end else begin
          tail_line_d  = res_line;
          tail_flush_d = res_flush;
        end
      end
      2'b01: begin
        count_d      = count_q - 2'd1;
        head_line_d  = tail_line_q;
        head_flush_d = tail_flush_q;
      end
      2'b11: begin
        // count is one here: replace the departing head
        head_line_d  = res_line;
        head_flush_d = res_flush;
      end
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_line_q  <= head_line_d;
    head_flush_q <= head_flush_d;
    tail_line_q  <= tail_line_d;
    tail_flush_q <= tail_flush_d;
  end

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue count out of range");

  a_queue_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !out_fire) |=> (count_q == $past(count_q) + 2'd1))
    else $error("line result not queued");

  a_line_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (head_line_q.line_bottom > {1'b0, head_line_q.line_top}))
    else $error("line end not past line start");

endmodule

`default_nettype wire
